// ===== hw/rtl/sorted_priority_queue_core_assert.svh =====
// Assertion macros used by the queue core RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed: same-cycle implication");

// Condition implies consequence in the following cycle.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed: next-cycle implication");

`endif

// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int TAG_BITS_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spq_in_if.sv =====
`default_nettype none
interface spq_in_if #(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                operation;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, output operation, output key, output tag, input ready);
  modport sink   (input valid, input operation, input key, input tag, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/spq_out_if.sv =====
`default_nettype none
interface spq_out_if #(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16,
  parameter int CNT_BITS = 7
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] head_key;
  logic [TAG_BITS-1:0] head_tag;
  logic [1:0]          status;
  logic [CNT_BITS-1:0] occupancy;

  modport source (output valid, output head_key, output head_tag, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input head_key, input head_tag, input status,
                  input occupancy, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none
module spq_cell #(
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire spq_pkg::cell_cmd_t  cmd,
  input  wire logic [KEY_BITS-1:0] new_key,
  input  wire logic [TAG_BITS-1:0] new_tag,
  input  wire logic                occupied,
  input  wire logic                prev_ge,
  input  wire logic [KEY_BITS-1:0] prev_key,
  input  wire logic [TAG_BITS-1:0] prev_tag,
  input  wire logic [KEY_BITS-1:0] next_key,
  input  wire logic [TAG_BITS-1:0] next_tag,
  output logic                     ge,
  output logic [KEY_BITS-1:0]      key,
  output logic [TAG_BITS-1:0]      tag
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0] key_next;
  logic [TAG_BITS-1:0] tag_next;

  // Entry stays ahead of the new key when it is at least as large.
  assign ge = occupied && (key >= new_key);

  always_comb begin
    key_next = key;
    tag_next = tag;
    if (cmd.pop) begin
      key_next = next_key;
      tag_next = next_tag;
    end else if (cmd.insert && !ge) begin
      if (prev_ge) begin
        key_next = new_key;
        tag_next = new_tag;
      end else begin
        key_next = prev_key;
        tag_next = prev_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue, a row of DEPTH entry cells ordered by descending key.
// request channel: operation (insert or pop), key, tag. One response per
// request on the response channel: popped head_key/head_tag (zero otherwise),
// status (ok, insert dropped because full, pop of empty queue) and occupancy
// after the operation.
// Every cell compares its key with the incoming one in parallel and shifts
// toward the tail on insert or toward the head on pop, so the whole queue
// updates together. Equal keys leave in arrival order.
// The response is registered and is valid in the cycle after the request transaction.
// Throughput: one transaction per cycle while the receiver takes responses.
// A single output register holds the response; when the receiver stalls,
// it holds and request.ready drops until the response is taken.
// Reset (rst, synchronous) empties the queue and drops any pending response;
// no clearing pass is needed, entries beyond the fill count are never read.
`default_nettype none
module sorted_priority_queue_core #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  spq_in_if.sink    request,
  spq_out_if.source response
);
  import spq_pkg::*;

  `include "sorted_priority_queue_core_assert.svh"

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                is_pop;
  cell_cmd_t           cmd;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  logic                cell_ge  [DEPTH];

  assign request.ready = !response.valid || response.ready;
  assign accept        = request.valid && request.ready;
  assign full          = (count == FULL_CNT);
  assign empty         = (count == '0);
  assign is_pop        = (request.operation == OP_POP);

  assign cmd.insert = accept && !is_pop && !full;
  assign cmd.pop    = accept && is_pop && !empty;

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CNT_BITS'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_BITS'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(i);
    logic                occupied;
    logic                prev_ge;
    logic [KEY_BITS-1:0] prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    logic [KEY_BITS-1:0] next_key;
    logic [TAG_BITS-1:0] next_tag;

    assign occupied = (IDX < count);

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_key = request.key;
      assign prev_tag = request.tag;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_tag = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = cell_key[i];
      assign next_tag = cell_tag[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_tag = cell_tag[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .new_key  (request.key),
      .new_tag  (request.tag),
      .occupied (occupied),
      .prev_ge  (prev_ge),
      .prev_key (prev_key),
      .prev_tag (prev_tag),
      .next_key (next_key),
      .next_tag (next_tag),
      .ge       (cell_ge[i]),
      .key      (cell_key[i]),
      .tag      (cell_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      response.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        response.valid <= 1'b1;
      end else if (response.ready) begin
        response.valid <= 1'b0;
      end
    end
    if (accept) begin
      response.occupancy <= count_next;
      response.head_key  <= cmd.pop ? cell_key[0] : '0;
      response.head_tag  <= cmd.pop ? cell_tag[0] : '0;
      if (is_pop && empty) begin
        response.status <= ST_EMPTY;
      end else if (!is_pop && full) begin
        response.status <= ST_FULL;
      end else begin
        response.status <= ST_OK;
      end
    end
  end

  `SPQ_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= FULL_CNT)
  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.insert, count == ($past(count) + CNT_BITS'(1)))
  `SPQ_ASSERT_NOW(a_head_sorted, clk, rst, count > CNT_BITS'(1), cell_key[0] >= cell_key[1])
  `SPQ_ASSERT_NOW(a_full_status, clk, rst, response.valid && (response.status == ST_FULL),
                  response.occupancy == FULL_CNT)

endmodule
`default_nettype wire
